// ----- rtl/core/byte_ring_buffer_peek_discard_core_macros.svh -----
// ---------------------------------------------------------------------------
// byte_ring_buffer_peek_discard_core_macros.svh
// Assertion macros for the port checks of the ring buffer.
// ---------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_PEEK_DISCARD_CORE_MACROS_SVH
`define BYTE_RING_BUFFER_PEEK_DISCARD_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define BRBPD_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BRBPD_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/brbpd_pkg.sv -----
// ---------------------------------------------------------------------------
// brbpd_pkg
// Types and constants for the circular byte queue with peek and discard.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package brbpd_pkg;

    localparam int DEPTH    = 1024;
    localparam int MAX_READ = 64;
    localparam int AW       = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int RW       = $clog2(MAX_READ + 1);

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_PEEK    = 2'd1,
        OP_DISCARD = 2'd2,
        OP_STATUS  = 2'd3
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_PEEK
    } state_t;

    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [7:0]    wr_data;
        logic          rd_en;
        logic [AW-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [7:0]       byte_out;
        logic             byte_valid;
        logic             last;
        logic [CNT_W-1:0] done_count;
        logic [CNT_W-1:0] stored_count;
        logic [CNT_W-1:0] free_count;
    } result_t;

    typedef struct packed {
        logic    load;
        result_t res;
    } out_ld_t;

    // pos < cap and n <= cap, so one subtract brings the sum back into range
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] pos,
                                                input logic [CNT_W-1:0] n,
                                                input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - AW){1'b0}}, pos} + {1'b0, n};
        if (sum >= {1'b0, cap})
        begin
            sum = sum - {1'b0, cap};
        end
        return sum[AW-1:0];
    endfunction

endpackage

// ----- rtl/core/brbpd_ram.sv -----
// ---------------------------------------------------------------------------
// brbpd_ram
// Byte store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module brbpd_ram
    import brbpd_pkg::*;
(
    input  logic       clk,
    input  mem_req_t   req,
    output logic [7:0] rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/brbpd_out.sv -----
// ---------------------------------------------------------------------------
// brbpd_out
// Result register: holds one result item until the receiver takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module brbpd_out
    import brbpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  out_ld_t          ld,
    input  logic             rsp_stall,
    output logic             rsp_valid,
    output logic [7:0]       byte_out,
    output logic             byte_valid,
    output logic             last,
    output logic [CNT_W-1:0] done_count,
    output logic [CNT_W-1:0] stored_count,
    output logic [CNT_W-1:0] free_count
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ld.load)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            res_reg <= ld.res;
        end
    end

    assign rsp_valid    = valid_reg;
    assign byte_out     = res_reg.byte_out;
    assign byte_valid   = res_reg.byte_valid;
    assign last         = res_reg.last;
    assign done_count   = res_reg.done_count;
    assign stored_count = res_reg.stored_count;
    assign free_count   = res_reg.free_count;

endmodule

// ----- rtl/core/brbpd_ctrl.sv -----
// ---------------------------------------------------------------------------
// brbpd_ctrl
// Queue pointers, capacity register and the peek read sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module brbpd_ctrl
    import brbpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [1:0]       opcode,
    input  logic [7:0]       byte_in,
    input  logic [AW-1:0]    offset,
    input  logic [CNT_W-1:0] count,
    input  logic             rsp_valid,
    input  logic             rsp_stall,
    output mem_req_t         mem_req,
    input  logic [7:0]       mem_rd_data,
    output out_ld_t          out_ld
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [AW-1:0]    rd_pos_reg, rd_pos_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic             pend_reg, pend_next;
    logic             pend_last_reg, pend_last_next;

    logic             out_free;
    logic             accept;
    logic             issue;
    logic             move;
    logic [CNT_W-1:0] off_ext;
    logic [CNT_W-1:0] avail;
    logic [CNT_W-1:0] peek_n1;
    logic [CNT_W-1:0] peek_n;
    logic [CNT_W-1:0] disc_n;
    logic [CNT_W-1:0] done_val;

    assign out_free  = !rsp_valid || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;

    assign off_ext = {{(CNT_W - AW){1'b0}}, offset};
    assign avail   = fill_reg - off_ext;
    assign peek_n1 = (count < avail) ? count : avail;
    assign peek_n  = (peek_n1 > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : peek_n1;
    assign disc_n  = (count < fill_reg) ? count : fill_reg;

    assign issue = (state_reg == ST_PEEK) && (rem_reg != '0) && (!pend_reg || out_free);
    assign move  = pend_reg && out_free;

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        rd_pos_next    = rd_pos_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        done_val       = '0;
        mem_req        = '0;
        out_ld         = '0;

        mem_req.wr_addr = tail_reg;
        mem_req.wr_data = byte_in;
        mem_req.rd_addr = rd_pos_reg;

        if (cfg_write)
        begin
            if (cfg_data == '0)
            begin
                cap_next = CNT_W'(1);
            end
            else if (cfg_data > CNT_W'(DEPTH))
            begin
                cap_next = CNT_W'(DEPTH);
            end
            else
            begin
                cap_next = cfg_data;
            end
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end
        else if (accept)
        begin
            case (opcode_t'(opcode))
                OP_WRITE:
                begin
                    if (fill_reg < cap_reg)
                    begin
                        mem_req.wr_en = 1'b1;
                        tail_next     = wrap_add(tail_reg, CNT_W'(1), cap_reg);
                        fill_next     = fill_reg + CNT_W'(1);
                        done_val      = CNT_W'(1);
                    end
                end
                OP_PEEK:
                begin
                    if ((count != '0) && (fill_reg != '0) && (off_ext < fill_reg))
                    begin
                        state_next  = ST_PEEK;
                        rd_pos_next = wrap_add(head_reg, off_ext, cap_reg);
                        rem_next    = peek_n[RW-1:0];
                    end
                end
                OP_DISCARD:
                begin
                    head_next = wrap_add(head_reg, disc_n, cap_reg);
                    fill_next = fill_reg - disc_n;
                    done_val  = disc_n;
                end
                default:
                begin
                    done_val = '0;
                end
            endcase

            if (opcode_t'(opcode) != OP_PEEK)
            begin
                out_ld.load             = 1'b1;
                out_ld.res.byte_out     = '0;
                out_ld.res.byte_valid   = 1'b0;
                out_ld.res.last         = 1'b1;
                out_ld.res.done_count   = done_val;
                out_ld.res.stored_count = fill_next;
                out_ld.res.free_count   = cap_reg - fill_next;
            end
        end

        // peek sequencer: each read is issued ahead of its hand-over, which waits for a free result register
        if (move)
        begin
            out_ld.load             = 1'b1;
            out_ld.res.byte_out     = mem_rd_data;
            out_ld.res.byte_valid   = 1'b1;
            out_ld.res.last         = pend_last_reg;
            out_ld.res.done_count   = '0;
            out_ld.res.stored_count = fill_reg;
            out_ld.res.free_count   = cap_reg - fill_reg;
            pend_next               = 1'b0;
        end

        if (issue)
        begin
            mem_req.rd_en  = 1'b1;
            rd_pos_next    = wrap_add(rd_pos_reg, CNT_W'(1), cap_reg);
            rem_next       = rem_reg - RW'(1);
            pend_next      = 1'b1;
            pend_last_next = (rem_reg == RW'(1));
        end

        if ((state_reg == ST_PEEK) && (rem_next == '0) && !pend_next)
        begin
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CNT_W'(DEPTH);
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            rd_pos_reg    <= '0;
            rem_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            rd_pos_reg    <= rd_pos_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

endmodule

// ----- rtl/core/byte_ring_buffer_peek_discard_core.sv -----
// ---------------------------------------------------------------------------
// byte_ring_buffer_peek_discard_core
// Circular byte queue with append, peek, bulk discard and status query.
//
// Request channel (req_valid / req_stall) carries opcode, byte_in, offset
// and count; response channel (rsp_valid / rsp_stall) carries one result
// item per transfer. cfg_write loads the capacity and empties the queue.
// Write, discard and status give one item, registered one cycle after
// acceptance; one such request can be taken every cycle.
// A peek gives min(count, stored - offset, 64) items, each read through the
// single read port of the byte store, then loaded into the result register
// one per cycle unless the receiver stalls; requests stall meanwhile.
// A peek that yields nothing produces no item and no stall.
// When the receiver stalls, the result register holds its item and the
// request side stalls until it drains.
// Reset: capacity 1024, queue empty; the byte store is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_ring_buffer_peek_discard_core
    import brbpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [1:0]       opcode,
    input  logic [7:0]       byte_in,
    input  logic [AW-1:0]    offset,
    input  logic [CNT_W-1:0] count,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic [7:0]       byte_out,
    output logic             byte_valid,
    output logic             last,
    output logic [CNT_W-1:0] done_count,
    output logic [CNT_W-1:0] stored_count,
    output logic [CNT_W-1:0] free_count
);

    mem_req_t   mem_req;
    logic [7:0] mem_rd_data;
    out_ld_t    out_ld;

    brbpd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .opcode      (opcode),
        .byte_in     (byte_in),
        .offset      (offset),
        .count       (count),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .out_ld      (out_ld)
    );

    brbpd_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    brbpd_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .ld           (out_ld),
        .rsp_stall    (rsp_stall),
        .rsp_valid    (rsp_valid),
        .byte_out     (byte_out),
        .byte_valid   (byte_valid),
        .last         (last),
        .done_count   (done_count),
        .stored_count (stored_count),
        .free_count   (free_count)
    );

endmodule

// ----- rtl/core/brbpd_checker.sv -----
// ---------------------------------------------------------------------------
// brbpd_port_checks
// Port-level checks on the response channel of the byte queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_ring_buffer_peek_discard_core_macros.svh"

module brbpd_port_checks
    import brbpd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             rsp_valid,
    input logic             rsp_stall,
    input logic [7:0]       byte_out,
    input logic             byte_valid,
    input logic             last,
    input logic [CNT_W-1:0] done_count,
    input logic [CNT_W-1:0] stored_count,
    input logic [CNT_W-1:0] free_count
);

    logic [CNT_W:0] cap_sum;

    assign cap_sum = {1'b0, stored_count} + {1'b0, free_count};

    `BRBPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
        rsp_valid && $stable(byte_out) && $stable(last) && $stable(stored_count),
        "stalled response item changed")
    `BRBPD_ASSERT_NOW(a_ctl_item, rsp_valid && !byte_valid,
        last && (byte_out == 8'd0), "non-peek item must be single and carry no byte")
    `BRBPD_ASSERT_NOW(a_peek_done, rsp_valid && byte_valid,
        done_count == '0, "peek item with non-zero done count")
    `BRBPD_ASSERT_NOW(a_cap_sum, rsp_valid,
        (cap_sum >= (CNT_W + 1)'(1)) && (cap_sum <= (CNT_W + 1)'(DEPTH)),
        "stored plus free outside capacity range")

endmodule

bind byte_ring_buffer_peek_discard_core brbpd_port_checks u_brbpd_port_checks (.*);

// ----- bench/brbpd_checker.sv -----
// ---------------------------------------------------------------------------
// brbpd_checker
// Watches the capacity port and both channels of the byte ring buffer,
// keeps its own copy of the ring, the pointers and the capacity, works out
// the items each accepted request should give and compares every accepted
// response item with the oldest one still owed. Reports failures and the
// number of items still owed to the bench top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module brbpd_checker
    import brbpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             req_valid,
    input  logic             req_stall,
    input  logic [1:0]       opcode,
    input  logic [7:0]       byte_in,
    input  logic [AW-1:0]    offset,
    input  logic [CNT_W-1:0] count,
    input  logic             rsp_valid,
    input  logic             rsp_stall,
    input  logic [7:0]       byte_out,
    input  logic             byte_valid,
    input  logic             last,
    input  logic [CNT_W-1:0] done_count,
    input  logic [CNT_W-1:0] stored_count,
    input  logic [CNT_W-1:0] free_count,
    output int               fails,
    output int               pending
);

    logic [7:0] ring [DEPTH];
    int         head;
    int         tail;
    int         fill;
    int         cap;
    result_t    owed_items [$];

    function automatic int ring_next(input int pos, input int n);
        int s;
        s = pos + n;
        if (s >= cap)
            s -= cap;
        return s;
    endfunction

    function automatic result_t fill_report(input logic [7:0] b, input logic v,
                                            input logic l, input int done);
        result_t r;
        r.byte_out     = b;
        r.byte_valid   = v;
        r.last         = l;
        r.done_count   = done[CNT_W-1:0];
        r.stored_count = fill[CNT_W-1:0];
        r.free_count   = CNT_W'(cap - fill);
        return r;
    endfunction

    task automatic ring_apply(input opcode_t op, input logic [7:0] b, input int off,
                              input int cnt);
        int n;
        int pos;
        int taken;
        case (op)
            OP_WRITE:
            begin
                taken = 0;
                if (fill < cap)
                begin
                    ring[tail] = b;
                    tail = ring_next(tail, 1);
                    fill++;
                    taken = 1;
                end
                owed_items.push_back(fill_report(8'h00, 1'b0, 1'b1, taken));
            end
            OP_PEEK:
            begin
                if (cnt != 0 && off < fill)
                begin
                    n = fill - off;
                    if (cnt < n)
                        n = cnt;
                    if (n > MAX_READ)
                        n = MAX_READ;
                    pos = ring_next(head, off);
                    for (int i = 0; i < n; i++)
                    begin
                        owed_items.push_back(fill_report(ring[pos], 1'b1, i == n - 1, 0));
                        pos = ring_next(pos, 1);
                    end
                end
            end
            OP_DISCARD:
            begin
                n = (cnt < fill) ? cnt : fill;
                head = ring_next(head, n);
                fill -= n;
                owed_items.push_back(fill_report(8'h00, 1'b0, 1'b1, n));
            end
            default:
            begin
                owed_items.push_back(fill_report(8'h00, 1'b0, 1'b1, 0));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t r;
        int      v;
        if (!rst_n)
        begin
            head = 0;
            tail = 0;
            fill = 0;
            cap  = DEPTH;
            fails = 0;
            owed_items.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                v = int'(cfg_data);
                if (v < 1)
                    v = 1;
                if (v > DEPTH)
                    v = DEPTH;
                cap  = v;
                head = 0;
                tail = 0;
                fill = 0;
            end
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                if (owed_items.size() == 0)
                begin
                    $error("response item with nothing owed");
                    fails++;
                end
                else
                begin
                    r = owed_items.pop_front();
                    check_field("byte_out", CNT_W'(r.byte_out), CNT_W'(byte_out));
                    check_field("byte_valid", CNT_W'(r.byte_valid), CNT_W'(byte_valid));
                    check_field("last", CNT_W'(r.last), CNT_W'(last));
                    check_field("done_count", r.done_count, done_count);
                    check_field("stored_count", r.stored_count, stored_count);
                    check_field("free_count", r.free_count, free_count);
                end
            end
            if (req_valid === 1'b1 && req_stall === 1'b0)
                ring_apply(opcode_t'(opcode), byte_in, int'(offset), int'(count));
            pending <= owed_items.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Bench for the byte ring buffer: a directed run over empty, full, zero
// count and out-of-range peeks, then random operation mixes under several
// capacities, the extremes among them, with random gaps on the request side
// and random stalls on the response side. Checking is done in brbpd_checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import brbpd_pkg::*;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_write = 1'b0;
    logic [CNT_W-1:0] cfg_data  = '0;
    logic             req_valid = 1'b0;
    logic [1:0]       opcode    = '0;
    logic [7:0]       byte_in   = '0;
    logic [AW-1:0]    offset    = '0;
    logic [CNT_W-1:0] count     = '0;
    logic             rsp_stall = 1'b0;
    logic             req_stall;
    logic             rsp_valid;
    logic [7:0]       byte_out;
    logic             byte_valid;
    logic             last;
    logic [CNT_W-1:0] done_count;
    logic [CNT_W-1:0] stored_count;
    logic [CNT_W-1:0] free_count;
    int               fails;
    int               pending;
    bit               calm = 1'b0;
    int               stall_left = 0;

    always #1 clk = ~clk;

    byte_ring_buffer_peek_discard_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .byte_in      (byte_in),
        .offset       (offset),
        .count        (count),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .byte_out     (byte_out),
        .byte_valid   (byte_valid),
        .last         (last),
        .done_count   (done_count),
        .stored_count (stored_count),
        .free_count   (free_count)
    );

    brbpd_checker watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .byte_in      (byte_in),
        .offset       (offset),
        .count        (count),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .byte_out     (byte_out),
        .byte_valid   (byte_valid),
        .last         (last),
        .done_count   (done_count),
        .stored_count (stored_count),
        .free_count   (free_count),
        .fails        (fails),
        .pending      (pending)
    );

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: fresh stall draw after every item taken
    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            stall_left = calm ? 0 : $urandom_range(0, 7);
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    task automatic send(input opcode_t op, input int b, input int off, input int cnt);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= op;
        byte_in   <= b[7:0];
        offset    <= off[AW-1:0];
        count     <= cnt[CNT_W-1:0];
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic settle;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_capacity(input int v);
        settle();
        cfg_write <= 1'b1;
        cfg_data  <= v[CNT_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int caps [7] = '{0, 1, 2, 5, 2047, 1023, 100};
        int pick;
        int off;
        int cnt;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity, empty queue first
        send(OP_STATUS, 0, 0, 0);
        send(OP_PEEK, 0, 0, 5);
        send(OP_DISCARD, 0, 0, 1024);
        send(OP_WRITE, 'h00, 0, 0);
        send(OP_WRITE, 'hFF, 1023, 2047);
        send(OP_WRITE, 'hA5, 0, 0);
        send(OP_WRITE, 'h5A, 0, 0);
        send(OP_PEEK, 0, 0, 1024);
        send(OP_PEEK, 0, 2, 1);
        send(OP_PEEK, 0, 3, 2047);
        send(OP_PEEK, 0, 4, 10);
        send(OP_PEEK, 0, 1023, 10);
        send(OP_PEEK, 0, 0, 0);
        send(OP_DISCARD, 0, 0, 0);
        send(OP_DISCARD, 0, 0, 1);
        send(OP_STATUS, 0, 0, 0);

        // single slot: second write finds it full
        set_capacity(1);
        send(OP_WRITE, 'h3C, 0, 0);
        send(OP_WRITE, 'hC3, 0, 0);
        send(OP_PEEK, 0, 0, 64);
        send(OP_DISCARD, 0, 0, 2047);
        send(OP_STATUS, 0, 0, 0);

        foreach (caps[p])
        begin
            set_capacity(caps[p]);
            calm = ($urandom_range(0, 3) == 0);
            if (caps[p] >= 64 && caps[p] < 2047)
            begin
                repeat (66) send(OP_WRITE, $urandom_range(0, 255), 0, 0);
                send(OP_PEEK, 0, 0, 1024);
            end
            repeat (16)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    send(OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 1023),
                         $urandom_range(0, 2047));
                end
                else if (pick < 72)
                begin
                    off = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 12);
                    case ($urandom_range(0, 9))
                        0:       cnt = 0;
                        1:       cnt = $urandom_range(0, 1) ? 2047 : 1024;
                        2, 3, 4: cnt = $urandom_range(65, 1024);
                        default: cnt = $urandom_range(1, 20);
                    endcase
                    send(OP_PEEK, $urandom_range(0, 255), off, cnt);
                end
                else if (pick < 90)
                begin
                    cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, 3);
                    send(OP_DISCARD, $urandom_range(0, 255), $urandom_range(0, 1023), cnt);
                end
                else
                begin
                    send(OP_STATUS, $urandom_range(0, 255), $urandom_range(0, 1023),
                         $urandom_range(0, 2047));
                end
            end
        end

        settle();
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
